// ----- rtl/rfc_pkg.sv -----
// Shared types and codes for the ring FIFO controller.
package rfc_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } rfc_func_e;

  localparam int unsigned DepthRegWidth = 9;
  localparam logic [DepthRegWidth-1:0] DepthRegReset = 9'd256;

  typedef struct packed {
    rfc_func_e   func;
    logic [31:0] push_data;
    logic [7:0]  advance_count;
    logic        burst_last;
  } rfc_in_t;

  typedef struct packed {
    logic [31:0] pop_data;
    logic        accepted;
    logic [7:0]  available;
    logic [7:0]  free_space;
    logic [7:0]  contiguous_run;
    logic        is_empty;
    logic [7:0]  burst_written;
  } rfc_out_t;

  typedef struct packed {
    logic                     wr;
    logic [DepthRegWidth-1:0] depth;
  } rfc_cfg_t;

endpackage

// ----- rtl/ring_fifo_controller_unit.sv -----
// Top level of the ring FIFO controller: APB register block and FIFO sequencer.
// Each item passes through accept, execute against the memory, and post the result.
// A new item is not accepted until the last result is posted, which waits while the
// output is stalled; the memory's registered read data on a pop sets the post step.
// A result waits in the output register; the next item is taken once it is posted.
// Reset empties the FIFO and sets depth_in_use to 256; memory contents are not cleared.
module ring_fifo_controller_unit
  import rfc_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rfc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rfc_out_t    out_data_o
);

  rfc_cfg_t cfg;

  rfc_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  rfc_engine #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/rfc_ram.sv -----
// Single-port-write, single-port-read element memory with registered read data.
module rfc_ram #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 8
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rfc_apb_regs.sv -----
// APB register block holding the depth-in-use setting.
module rfc_apb_regs
  import rfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rfc_cfg_t    cfg_o
);

  logic [DepthRegWidth-1:0] depth_q;
  logic                     wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthRegReset;
    end else begin
      if (wr_hit) begin
        depth_q <= pwdata[DepthRegWidth-1:0];
      end
    end
  end

  assign prdata    = (paddr[2] == 1'b0) ? {{(32 - DepthRegWidth){1'b0}}, depth_q} : 32'd0;
  assign cfg_o.wr    = wr_hit;
  assign cfg_o.depth = depth_q;

endmodule

// ----- rtl/rfc_engine.sv -----
// Pointer sequencer: reads, updates and writes back the FIFO state around the memory.
module rfc_engine
  import rfc_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rfc_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rfc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rfc_out_t out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = ((PW > DepthRegWidth) ? PW : DepthRegWidth) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POST
  } state_e;

  state_e                state_q;
  rfc_in_t               item_q;
  logic [PW-1:0]         rd_ptr_q;
  logic [PW-1:0]         wr_ptr_q;
  logic [7:0]            tally_q;
  logic                  res_acc_q;
  logic                  res_pop_q;
  logic [7:0]            res_burst_q;
  logic                  out_valid_q;
  rfc_out_t              out_q;

  logic [CW-1:0]         n_w;
  logic [CW-1:0]         depth_w;
  logic [CW-1:0]         rd_w;
  logic [CW-1:0]         wr_w;
  logic [CW-1:0]         avail_w;
  logic [CW-1:0]         run_w;
  logic [CW-1:0]         free_w;
  logic [CW-1:0]         rd_inc_w;
  logic [CW-1:0]         wr_inc_w;
  logic [CW-1:0]         rd_next_w;
  logic [CW-1:0]         wr_next_w;
  logic [CW-1:0]         count_w;
  logic [CW-1:0]         drop_w;
  logic [CW-1:0]         rd_adv_w;
  logic [CW-1:0]         rd_adv_wrap_w;
  logic                  push_ok;
  logic                  pop_ok;
  logic [7:0]            tally_inc;
  logic                  mem_we;
  logic                  mem_re;
  logic [DATA_WIDTH-1:0] mem_rdata;
  rfc_out_t              res;

  assign depth_w = CW'(cfg_i.depth);
  assign n_w = (depth_w < CW'(2)) ? CW'(2) : ((depth_w > CW'(DEPTH)) ? CW'(DEPTH) : depth_w);

  assign rd_w    = CW'(rd_ptr_q);
  assign wr_w    = CW'(wr_ptr_q);
  assign avail_w = (rd_w > wr_w) ? (n_w - (rd_w - wr_w)) : (wr_w - rd_w);
  assign run_w   = (wr_w < rd_w) ? (n_w - rd_w) : (wr_w - rd_w);
  assign free_w  = n_w - CW'(1) - avail_w;

  assign push_ok   = avail_w < (n_w - CW'(1));
  assign pop_ok    = avail_w != '0;
  assign rd_inc_w  = rd_w + CW'(1);
  assign wr_inc_w  = wr_w + CW'(1);
  assign rd_next_w = (rd_inc_w == n_w) ? '0 : rd_inc_w;
  assign wr_next_w = (wr_inc_w == n_w) ? '0 : wr_inc_w;

  assign count_w       = CW'(item_q.advance_count);
  assign drop_w        = (count_w > avail_w) ? avail_w : count_w;
  assign rd_adv_w      = rd_w + drop_w;
  assign rd_adv_wrap_w = (rd_adv_w >= n_w) ? (rd_adv_w - n_w) : rd_adv_w;

  assign tally_inc = (tally_q == 8'hFF) ? tally_q : (tally_q + 8'd1);

  assign mem_we = (state_q == ST_EXEC) && (item_q.func == FUNC_PUSH) && push_ok;
  assign mem_re = (state_q == ST_EXEC) && (item_q.func == FUNC_POP) && pop_ok;

  rfc_ram #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .AW        (PW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(DATA_WIDTH'(item_q.push_data)),
    .re_i   (mem_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    res.pop_data       = res_pop_q ? 32'(mem_rdata) : 32'd0;
    res.accepted       = res_acc_q;
    res.available      = avail_w[7:0];
    res.free_space     = free_w[7:0];
    res.contiguous_run = run_w[7:0];
    res.is_empty       = (rd_ptr_q == wr_ptr_q);
    res.burst_written  = res_burst_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_POST)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_pop_q   <= 1'b0;
          res_burst_q <= 8'd0;
          case (item_q.func)
            FUNC_PUSH: begin
              res_acc_q <= push_ok;
              if (push_ok) begin
                wr_ptr_q <= wr_next_w[PW-1:0];
              end
              if (item_q.burst_last) begin
                res_burst_q <= push_ok ? tally_inc : tally_q;
                tally_q     <= 8'd0;
              end else if (push_ok) begin
                tally_q <= tally_inc;
              end
            end
            FUNC_POP: begin
              res_acc_q <= pop_ok;
              res_pop_q <= pop_ok;
              if (pop_ok) begin
                rd_ptr_q <= rd_next_w[PW-1:0];
              end
            end
            FUNC_ADVANCE: begin
              res_acc_q <= (count_w <= avail_w);
              rd_ptr_q  <= rd_adv_wrap_w[PW-1:0];
            end
            default: begin
              res_acc_q <= 1'b1;
              rd_ptr_q  <= '0;
              wr_ptr_q  <= '0;
              tally_q   <= '0;
            end
          endcase
          state_q <= ST_POST;
        end
        ST_POST: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_i.wr) begin
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
        tally_q  <= '0;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_w < n_w) && (wr_w < n_w))
    else $error("FIFO pointer outside the slots in use");

  a_avail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avail_w <= (n_w - CW'(1)))
    else $error("FIFO holds more than the slots in use allow");

  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ptr_q == wr_ptr_q) |-> (avail_w == '0))
    else $error("Equal pointers with a nonzero element count");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("Memory written and read by the same item");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC))
    else $error("Accepted transfer did not start execution");

endmodule
